// File: rtl/core/embs_pkg.sv
`default_nettype none
package embs_pkg;
  localparam int FRAME_COLS_DEF = 188;
  localparam int FRAME_ROWS_DEF = 120;
  localparam int LANE_NEAR_OFFSET = 8;
  localparam int QDEPTH = 4;

  localparam logic [3:0] MODE_LOAD = 4'd0;
  localparam logic [3:0] MODE_L_EDGE = 4'd1;
  localparam logic [3:0] MODE_R_EDGE = 4'd2;
  localparam logic [3:0] MODE_UP = 4'd3;
  localparam logic [3:0] MODE_DOWN = 4'd4;
  localparam logic [3:0] MODE_L_NON = 4'd5;
  localparam logic [3:0] MODE_R_NON = 4'd6;
  localparam logic [3:0] MODE_UL_HALF = 4'd7;
  localparam logic [3:0] MODE_UL_DIAG = 4'd8;
  localparam logic [3:0] MODE_UR_HALF = 4'd9;
  localparam logic [3:0] MODE_UR_DIAG = 4'd10;
  localparam logic [3:0] MODE_DL_DIAG = 4'd11;
  localparam logic [3:0] MODE_DR_DIAG = 4'd12;
  localparam logic [3:0] MODE_LANE_L = 4'd13;
  localparam logic [3:0] MODE_LANE_R = 4'd14;

  localparam logic [2:0] REG_LEFT = 3'd0;
  localparam logic [2:0] REG_RIGHT = 3'd1;
  localparam logic [2:0] REG_UP = 3'd2;
  localparam logic [2:0] REG_DOWN = 3'd3;
  localparam logic [2:0] REG_THR = 3'd4;
  localparam logic [2:0] REG_GATE = 3'd5;
  localparam logic [2:0] REG_LANE = 3'd6;

  typedef struct packed {
    logic [3:0] mode;
    logic [6:0] row;
    logic [7:0] col;
    logic [7:0] gray;
    logic       edge_flag;
  } item_t;

  typedef struct packed {
    logic [7:0] left_bound;
    logic [7:0] right_bound;
    logic [6:0] up_bound;
    logic [6:0] down_bound;
    logic [7:0] light_threshold;
    logic       dark_gate_enable;
    logic [5:0] lane_offset;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LANE0, ST_READ, ST_WAIT, ST_P0, ST_P1, ST_P2, ST_P3, ST_EVAL, ST_OUT
  } st_t;
endpackage
`default_nettype wire

// File: rtl/core/edge_map_boundary_search.sv
`default_nettype none
// Channel | Direction | Signals
// in      | input     | in_valid/in_ready, mode row col gray edge_flag
// out     | output    | out_valid/out_ready, found_row found_col
// cfg     | input     | APB psel penable pwrite paddr pwdata prdata pready
//
// A load transaction is written to the frame store as it leaves the queue.
// The length of a query's pass per pixel tested is set by the single read port of
// the frame store (four reads for the dark gate window and test pixel), plus output.
// Reset is synchronous and clears the queue, the state machine and the config registers;
// the frame store is not cleared. The input queue lets loads enter while a walk runs.
module edge_map_boundary_search #(
  parameter int FRAME_COLS = embs_pkg::FRAME_COLS_DEF,
  parameter int FRAME_ROWS = embs_pkg::FRAME_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  mode,
  input  wire logic [6:0]  row,
  input  wire logic [7:0]  col,
  input  wire logic [7:0]  gray,
  input  wire logic        edge_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       found_row,
  output logic [7:0]       found_col,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  embs_pkg::cfg_t cfg;
  embs_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign in_item = '{mode: mode, row: row, col: col, gray: gray, edge_flag: edge_flag};

  // Register file: index is the word address.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_bound <= 8'd0;
      cfg.right_bound <= 8'd187;
      cfg.up_bound <= 7'd1;
      cfg.down_bound <= 7'd119;
      cfg.light_threshold <= 8'd128;
      cfg.dark_gate_enable <= 1'b0;
      cfg.lane_offset <= 6'd5;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (ridx)
        embs_pkg::REG_LEFT: cfg.left_bound <= pwdata[7:0];
        embs_pkg::REG_RIGHT: cfg.right_bound <= pwdata[7:0];
        embs_pkg::REG_UP: cfg.up_bound <= pwdata[6:0];
        embs_pkg::REG_DOWN: cfg.down_bound <= pwdata[6:0];
        embs_pkg::REG_THR: cfg.light_threshold <= pwdata[7:0];
        embs_pkg::REG_GATE: cfg.dark_gate_enable <= pwdata[0];
        embs_pkg::REG_LANE: cfg.lane_offset <= pwdata[5:0];
        default: begin end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      embs_pkg::REG_LEFT: prdata = {24'd0, cfg.left_bound};
      embs_pkg::REG_RIGHT: prdata = {24'd0, cfg.right_bound};
      embs_pkg::REG_UP: prdata = {25'd0, cfg.up_bound};
      embs_pkg::REG_DOWN: prdata = {25'd0, cfg.down_bound};
      embs_pkg::REG_THR: prdata = {24'd0, cfg.light_threshold};
      embs_pkg::REG_GATE: prdata = {31'd0, cfg.dark_gate_enable};
      embs_pkg::REG_LANE: prdata = {26'd0, cfg.lane_offset};
      default: prdata = 32'd0;
    endcase
  end

  embs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  embs_back #(.FRAME_COLS(FRAME_COLS), .FRAME_ROWS(FRAME_ROWS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
    .found_row(found_row), .found_col(found_col)
  );
endmodule
`default_nettype wire

// File: rtl/core/embs_front.sv
`default_nettype none
// Input side: accepts transactions, drops unused modes, and queues the rest.
module embs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire embs_pkg::item_t in_item,
  output logic               q_valid,
  input  wire logic          q_ready,
  output embs_pkg::item_t    q_item
);
  localparam int AW = $clog2(embs_pkg::QDEPTH);
  embs_pkg::item_t mem [embs_pkg::QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != (AW+1)'(embs_pkg::QDEPTH));
  assign push = in_valid && in_ready && (in_item.mode != 4'd15);
  assign q_valid = (cnt != '0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/embs_back.sv
`default_nettype none
// Executes loads and walks against the frame store, one pixel test per pass.
module embs_back #(
  parameter int FRAME_COLS = embs_pkg::FRAME_COLS_DEF,
  parameter int FRAME_ROWS = embs_pkg::FRAME_ROWS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire embs_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire embs_pkg::item_t q_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [6:0]           found_row,
  output logic [7:0]           found_col
);
  localparam int DEPTH = FRAME_COLS * FRAME_ROWS;
  localparam int AW = $clog2(DEPTH);

  logic [8:0] mem [DEPTH];
  logic [8:0] rdata;
  logic [AW-1:0] raddr;
  logic rd_en, rd_oob, rd_oob_q;

  embs_pkg::st_t st, st_next;
  logic [3:0] mode;
  logic signed [11:0] r, c;     // walk position
  logic signed [11:0] tr, tc;   // clamped test position
  logic [1:0] phase;            // lane: 0 first test, 1 walking
  logic want, dir_l, skip, inv, last_edge;
  logic [2:0] dark;
  logic edge_bit;
  logic [6:0] res_r;
  logic [7:0] res_c;

  // Clamp of the walk position to the bound window.
  logic signed [11:0] cr, cc;
  always_comb begin
    cr = r;
    if (cr > $signed({5'd0, cfg.down_bound})) cr = $signed({5'd0, cfg.down_bound});
    if (cr < $signed({5'd0, cfg.up_bound})) cr = $signed({5'd0, cfg.up_bound});
    cc = c;
    if (cc <= $signed({4'd0, cfg.left_bound})) cc = $signed({4'd0, cfg.left_bound}) + 12'sd1;
    if (cc > $signed({4'd0, cfg.right_bound})) cc = $signed({4'd0, cfg.right_bound});
  end

  // Read port address selection for the gate pixels and the test pixel.
  // The first read is issued while the clamped position is still being
  // registered, so it takes the clamp output directly.
  logic signed [11:0] pr, pc;
  always_comb begin
    pr = tr;
    pc = tc;
    case (st)
      embs_pkg::ST_READ: begin pr = cr - 12'sd1; pc = cc - 12'sd1; end
      embs_pkg::ST_P0: begin pr = tr - 12'sd1; pc = tc; end
      embs_pkg::ST_P1: begin pr = tr; pc = tc - 12'sd1; end
      default: begin pr = tr; pc = tc; end
    endcase
    rd_oob = (pr < 0) || (pr >= FRAME_ROWS) || (pc < 0) || (pc >= FRAME_COLS);
    raddr = AW'(pr) * AW'(FRAME_COLS) + AW'(pc);
  end

  logic load_wr, load_oob;
  logic [AW-1:0] waddr;
  assign load_oob = (q_item.row >= FRAME_ROWS) || (q_item.col >= FRAME_COLS);
  assign waddr = AW'(q_item.row) * AW'(FRAME_COLS) + AW'(q_item.col);
  assign load_wr = q_valid && q_ready && (q_item.mode == embs_pkg::MODE_LOAD) && !load_oob;

  always_ff @(posedge clk) begin
    if (load_wr) mem[waddr] <= {q_item.gray, q_item.edge_flag};
    if (rd_en) rdata <= rd_oob ? 9'h1FE : mem[raddr];
    rd_oob_q <= rd_oob;
  end

  wire pix_dark = (rdata[8:1] < cfg.light_threshold);
  wire [2:0] dark_nx = dark + 3'(pix_dark);

  // Walk control: does the current position still permit a test, and the step.
  logic row_ok, col_ok, cont;
  logic signed [11:0] sr, sc;
  always_comb begin
    row_ok = 1'b1;
    col_ok = 1'b1;
    sr = r;
    sc = c;
    case (mode)
      embs_pkg::MODE_L_EDGE, embs_pkg::MODE_L_NON: begin
        col_ok = c > $signed({4'd0, cfg.left_bound}); sc = c - 12'sd1;
      end
      embs_pkg::MODE_R_EDGE, embs_pkg::MODE_R_NON: begin
        col_ok = c < $signed({4'd0, cfg.right_bound}); sc = c + 12'sd1;
      end
      embs_pkg::MODE_UP: begin
        row_ok = r > $signed({5'd0, cfg.up_bound}); sr = r - 12'sd1;
      end
      embs_pkg::MODE_DOWN: begin
        row_ok = r < $signed({5'd0, cfg.down_bound}); sr = r + 12'sd1;
      end
      embs_pkg::MODE_UL_HALF, embs_pkg::MODE_UL_DIAG, embs_pkg::MODE_UR_HALF,
      embs_pkg::MODE_UR_DIAG: begin
        row_ok = r > $signed({5'd0, cfg.up_bound});
        if (!skip || !(mode == embs_pkg::MODE_UL_HALF || mode == embs_pkg::MODE_UR_HALF))
          sr = r - 12'sd1;
        if (mode == embs_pkg::MODE_UL_HALF || mode == embs_pkg::MODE_UL_DIAG) begin
          col_ok = c > $signed({4'd0, cfg.left_bound}); sc = c - 12'sd1;
        end else begin
          col_ok = c < $signed({4'd0, cfg.right_bound}); sc = c + 12'sd1;
        end
      end
      embs_pkg::MODE_DL_DIAG, embs_pkg::MODE_DR_DIAG: begin
        row_ok = r < $signed({5'd0, cfg.down_bound}); sr = r + 12'sd1;
        if (mode == embs_pkg::MODE_DL_DIAG) begin
          col_ok = c > $signed({4'd0, cfg.left_bound}); sc = c - 12'sd1;
        end else begin
          col_ok = c < $signed({4'd0, cfg.right_bound}); sc = c + 12'sd1;
        end
      end
      default: begin
        if (dir_l) begin
          col_ok = c > $signed({4'd0, cfg.left_bound}); sc = c - 12'sd1;
        end else begin
          col_ok = c < $signed({4'd0, cfg.right_bound}); sc = c + 12'sd1;
        end
      end
    endcase
    cont = row_ok && col_ok;
  end

  // Saturated result.
  logic signed [11:0] fr, fc;
  always_comb begin
    fr = r;
    fc = c;
    case (mode)
      embs_pkg::MODE_L_EDGE, embs_pkg::MODE_L_NON, embs_pkg::MODE_R_EDGE,
      embs_pkg::MODE_R_NON: begin
        if (!cont) fc = dir_l ? $signed({4'd0, cfg.left_bound})
                              : $signed({4'd0, cfg.right_bound});
      end
      embs_pkg::MODE_UP: if (!cont) fr = $signed({5'd0, cfg.up_bound});
      embs_pkg::MODE_DOWN: if (!cont) fr = $signed({5'd0, cfg.down_bound});
      embs_pkg::MODE_LANE_L, embs_pkg::MODE_LANE_R: begin
        if (!cont) fc = dir_l ? $signed({4'd0, cfg.left_bound})
                              : $signed({4'd0, cfg.right_bound});
        if (inv) fc = dir_l ? fc + 12'sd1 : fc - 12'sd1;
      end
      default: begin end
    endcase
  end

  logic signed [11:0] r_n, c_n;
  logic [1:0] phase_n;
  logic want_n, dir_l_n, skip_n, inv_n;
  always_comb begin
    st_next = st;
    q_ready = 1'b0;
    rd_en = 1'b0;
    r_n = r; c_n = c; phase_n = phase; want_n = want; dir_l_n = dir_l;
    skip_n = skip; inv_n = inv;
    case (st)
      embs_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_item.mode != embs_pkg::MODE_LOAD) begin
          r_n = $signed({5'd0, q_item.row});
          c_n = $signed({4'd0, q_item.col});
          skip_n = 1'b0; inv_n = 1'b0; phase_n = 2'd1;
          want_n = !(q_item.mode == embs_pkg::MODE_L_NON ||
                     q_item.mode == embs_pkg::MODE_R_NON);
          dir_l_n = (q_item.mode == embs_pkg::MODE_L_EDGE ||
                     q_item.mode == embs_pkg::MODE_L_NON ||
                     q_item.mode == embs_pkg::MODE_LANE_L);
          if (q_item.mode == embs_pkg::MODE_LANE_L ||
              q_item.mode == embs_pkg::MODE_LANE_R) begin
            phase_n = 2'd0;
            st_next = embs_pkg::ST_LANE0;
          end else begin
            st_next = embs_pkg::ST_READ;
          end
        end
      end
      embs_pkg::ST_LANE0: begin
        if (r == $signed({5'd0, cfg.down_bound}) - 12'sd1) begin
          c_n = (mode == embs_pkg::MODE_LANE_L) ? c + 12'(embs_pkg::LANE_NEAR_OFFSET)
                                                : c - 12'(embs_pkg::LANE_NEAR_OFFSET);
        end else begin
          c_n = (mode == embs_pkg::MODE_LANE_L) ? c + $signed({6'd0, cfg.lane_offset})
                                                : c - $signed({6'd0, cfg.lane_offset});
        end
        if (mode == embs_pkg::MODE_LANE_L) begin
          if (c_n > $signed({4'd0, cfg.right_bound})) c_n = $signed({4'd0, cfg.right_bound});
        end else begin
          if (c_n <= $signed({4'd0, cfg.left_bound}))
            c_n = $signed({4'd0, cfg.left_bound}) + 12'sd1;
        end
        st_next = embs_pkg::ST_READ;
      end
      embs_pkg::ST_READ: begin
        if (phase == 2'd1 && !cont) st_next = embs_pkg::ST_OUT;
        else begin
          rd_en = 1'b1;
          st_next = embs_pkg::ST_P0;
        end
      end
      embs_pkg::ST_P0: begin rd_en = 1'b1; st_next = embs_pkg::ST_P1; end
      embs_pkg::ST_P1: begin rd_en = 1'b1; st_next = embs_pkg::ST_P2; end
      embs_pkg::ST_P2: begin rd_en = 1'b1; st_next = embs_pkg::ST_P3; end
      embs_pkg::ST_P3: st_next = embs_pkg::ST_EVAL;
      embs_pkg::ST_EVAL: begin
        if (phase == 2'd0) begin
          // First lane test picks the walk: toward an edge, or off the edge band.
          phase_n = 2'd1;
          if (edge_bit) begin
            want_n = 1'b0; inv_n = 1'b1; dir_l_n = (mode == embs_pkg::MODE_LANE_R);
          end else begin
            want_n = 1'b1; dir_l_n = (mode == embs_pkg::MODE_LANE_L);
          end
          st_next = embs_pkg::ST_READ;
        end else if (edge_bit == want) begin
          st_next = embs_pkg::ST_OUT;
        end else begin
          r_n = sr; c_n = sc;
          skip_n = !skip;
          st_next = embs_pkg::ST_READ;
        end
      end
      embs_pkg::ST_OUT: if (out_ready) st_next = embs_pkg::ST_IDLE;
      default: st_next = embs_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = (st == embs_pkg::ST_OUT);
  assign found_row = res_r;
  assign found_col = res_c;
  assign edge_bit = last_edge && !(cfg.dark_gate_enable && dark_nx == 3'd0);

  always_ff @(posedge clk) begin
    if (st == embs_pkg::ST_READ) begin
      tr <= cr; tc <= cc; dark <= '0;
    end
    if (st == embs_pkg::ST_P0 || st == embs_pkg::ST_P1 || st == embs_pkg::ST_P2)
      dark <= dark_nx;
    if (st == embs_pkg::ST_P3) last_edge <= rdata[0] && !rd_oob_q;
    if (st == embs_pkg::ST_IDLE) mode <= q_item.mode;
    r <= r_n; c <= c_n; phase <= phase_n; want <= want_n; dir_l <= dir_l_n;
    skip <= skip_n; inv <= inv_n;
    if (st_next == embs_pkg::ST_OUT && st != embs_pkg::ST_OUT) begin
      res_r <= (fr < 0) ? 7'd0 : (fr > 12'sd127) ? 7'd127 : fr[6:0];
      res_c <= (fc < 0) ? 8'd0 : (fc > 12'sd255) ? 8'd255 : fc[7:0];
    end
    if (rst) st <= embs_pkg::ST_IDLE;
    else st <= st_next;
  end
  // dark accumulates the three gate pixels read in READ, P0 and P1; the fourth,
  // the test pixel read in P2, is added combinationally in EVAL.
endmodule
`default_nettype wire
